// ===== src/tmtf_pkg.sv =====
// Shared types and constants for the three-axis momentum tracking filter.
`default_nettype none

package tmtf_pkg;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int DT_W      = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_PNV = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MNV = 1'b1;

  localparam logic REQ_UPDATE = 1'b1;

  localparam logic ALU_MUL = 1'b0;
  localparam logic ALU_DIV = 1'b1;

  typedef struct packed {
    logic start;
    logic op;
  } alu_ctl_t;

endpackage

`default_nettype wire

// ===== src/three_axis_momentum_tracking_filter.sv =====
// Predict or first update: three multiplies.
// Primed update: 7 multiplies and 4 divides, or 3 divides when the gain denominator is zero.
// One item at a time through the shared multiply/divide unit.
// A finished word waits in the output register while the next item is taken.
// Reset (rst, synchronous): estimate and rate zero, variance 1.0, both noise registers 1.0.
`default_nettype none

module three_axis_momentum_tracking_filter #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 wr_en,
  input  wire logic [tmtf_pkg::CFG_IDX_W-1:0]       wr_index,
  input  wire logic [tmtf_pkg::CFG_W-1:0]           wr_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 req_type,
  input  wire logic signed [VALUE_WIDTH-1:0]        obs_x,
  input  wire logic signed [VALUE_WIDTH-1:0]        obs_y,
  input  wire logic signed [VALUE_WIDTH-1:0]        obs_z,
  input  wire logic [tmtf_pkg::DT_W-1:0]            time_step,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [VALUE_WIDTH-1:0]             out_x,
  output logic signed [VALUE_WIDTH-1:0]             out_y,
  output logic signed [VALUE_WIDTH-1:0]             out_z,
  output logic                                      was_primed
);

  localparam int W   = VALUE_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int CW  = tmtf_pkg::CFG_W;
  localparam int DTW = tmtf_pkg::DT_W;
  // operand width of the shared unit: values, variance and gain up to 1.0
  localparam int RW  = (W > F + 1) ? W : F + 1;
  // multiplier operand: dt or gain
  localparam int BW  = (F + 1 > DTW) ? F + 1 : DTW;
  // gain denominator: predicted variance plus measurement noise
  localparam int DW  = ((W > CW) ? W : CW) + 1;
  localparam int PCW = ((RW > CW) ? RW : CW) + 1;

  localparam logic [RW-1:0] LIM_ONE = RW'(1) << F;
  localparam logic [RW-1:0] LIM_NEG = RW'(1) << (W - 1);
  localparam logic [RW-1:0] LIM_POS = RW'({(W-1){1'b1}});
  localparam logic [RW-1:0] LIM_VAL = RW'({W{1'b1}});
  localparam logic [1:0]    LAST_AX = 2'd2;

  // sequencer: each ISS state launches one pass (GAIN skips it on a zero denominator), its WAIT state collects it
  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_PRED_ISS  = 4'd1;
  localparam logic [3:0] ST_PRED_WAIT = 4'd2;
  localparam logic [3:0] ST_GAIN_ISS  = 4'd3;
  localparam logic [3:0] ST_GAIN_WAIT = 4'd4;
  localparam logic [3:0] ST_CORR_ISS  = 4'd5;
  localparam logic [3:0] ST_CORR_WAIT = 4'd6;
  localparam logic [3:0] ST_RATE_ISS  = 4'd7;
  localparam logic [3:0] ST_RATE_WAIT = 4'd8;
  localparam logic [3:0] ST_VAR_ISS   = 4'd9;
  localparam logic [3:0] ST_VAR_WAIT  = 4'd10;
  localparam logic [3:0] ST_OUT       = 4'd11;

  logic [3:0] state;
  logic [1:0] ax;

  // filter state
  logic signed [W-1:0] est  [3];
  logic signed [W-1:0] rate [3];
  logic [RW-1:0]       err_var;
  logic                primed;
  logic [CW-1:0]       pnv;
  logic [CW-1:0]       mnv;

  // per-item working registers
  logic signed [W-1:0] obs_r [3];
  logic signed [W-1:0] pred  [3];
  logic [DTW-1:0]      dt_r;
  logic                upd_r;
  logic                was_r;
  logic [RW-1:0]       gain;
  logic                neg_r;

  logic [PCW-1:0]      pcov_sum;
  logic [W-1:0]        pcov;
  logic [DW-1:0]       den;
  logic                den_zero;
  logic [RW-1:0]       one_m_gain;

  logic signed [W+1:0] innov;
  logic signed [W+1:0] corr;
  logic signed [W+1:0] res_s;
  logic signed [W+1:0] sr;
  logic signed [W+1:0] pred_sum;
  logic signed [W+1:0] est_sum;
  logic [W-1:0]        rate_mag;
  logic [W-1:0]        innov_mag;
  logic [W-1:0]        corr_mag;

  tmtf_pkg::alu_ctl_t  alu_ctl;
  logic [RW-1:0]       alu_a;
  logic [BW-1:0]       alu_b;
  logic [DW-1:0]       alu_d;
  logic [RW-1:0]       alu_lim;
  logic                alu_done;
  logic [RW-1:0]       alu_res;
  logic                issue_neg;

  logic                in_take;
  logic                out_load;

  function automatic logic signed [W-1:0] sat_w(input logic signed [W+1:0] v);
    logic signed [W-1:0] r;
    if (v[W+1:W-1] == 3'b000 || v[W+1:W-1] == 3'b111) begin
      r = v[W-1:0];
    end else if (v[W+1]) begin
      r = {1'b1, {(W-1){1'b0}}};
    end else begin
      r = {1'b0, {(W-1){1'b1}}};
    end
    return r;
  endfunction

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_load = (state == ST_OUT) && (!out_valid || !out_stall);

  // predicted variance saturates to the value range before the gain division
  always_comb begin
    pcov_sum   = PCW'(err_var) + PCW'(pnv);
    pcov       = (pcov_sum > PCW'({W{1'b1}})) ? {W{1'b1}} : pcov_sum[W-1:0];
    den        = DW'(pcov) + DW'(mnv);
    den_zero   = (den == '0);
    one_m_gain = LIM_ONE - gain;
  end

  // magnitudes and signed sums for the current axis
  always_comb begin
    rate_mag  = rate[ax][W-1] ? (~rate[ax] + W'(1)) : rate[ax];
    innov     = (W+2)'(obs_r[ax]) - (W+2)'(pred[ax]);
    innov_mag = innov[W+1] ? W'(-innov) : W'(innov);
    corr      = (W+2)'(est[ax]) - (W+2)'(pred[ax]);
    corr_mag  = corr[W+1] ? W'(-corr) : W'(corr);
    res_s     = signed'((W+2)'(alu_res));
    sr        = neg_r ? -res_s : res_s;
    pred_sum  = (W+2)'(est[ax]) + sr;
    est_sum   = (W+2)'(pred[ax]) + sr;
  end

  // operands for the shared unit, chosen by the sequencer state
  always_comb begin
    alu_ctl   = '0;
    alu_a     = '0;
    alu_b     = '0;
    alu_d     = '0;
    alu_lim   = '0;
    issue_neg = 1'b0;
    unique case (state)
      ST_PRED_ISS: begin
        // rate * dt
        alu_ctl.start = 1'b1;
        alu_ctl.op    = tmtf_pkg::ALU_MUL;
        alu_a         = RW'(rate_mag);
        alu_b         = BW'(dt_r);
        alu_lim       = rate[ax][W-1] ? LIM_NEG : LIM_POS;
        issue_neg     = rate[ax][W-1];
      end
      ST_GAIN_ISS: begin
        // gain = pcov / den; a zero denominator skips the pass
        alu_ctl.start = !den_zero;
        alu_ctl.op    = tmtf_pkg::ALU_DIV;
        alu_a         = RW'(pcov);
        alu_d         = den;
        alu_lim       = LIM_ONE;
      end
      ST_CORR_ISS: begin
        // innovation * gain
        alu_ctl.start = 1'b1;
        alu_ctl.op    = tmtf_pkg::ALU_MUL;
        alu_a         = RW'(innov_mag);
        alu_b         = BW'(gain);
        alu_lim       = innov[W+1] ? LIM_NEG : LIM_POS;
        issue_neg     = innov[W+1];
      end
      ST_RATE_ISS: begin
        // correction / dt
        alu_ctl.start = 1'b1;
        alu_ctl.op    = tmtf_pkg::ALU_DIV;
        alu_a         = RW'(corr_mag);
        alu_d         = DW'(dt_r);
        alu_lim       = corr[W+1] ? LIM_NEG : LIM_POS;
        issue_neg     = corr[W+1];
      end
      ST_VAR_ISS: begin
        // pcov * (1 - gain)
        alu_ctl.start = 1'b1;
        alu_ctl.op    = tmtf_pkg::ALU_MUL;
        alu_a         = RW'(pcov);
        alu_b         = BW'(one_m_gain);
        alu_lim       = LIM_VAL;
      end
      default: begin
      end
    endcase
  end

  tmtf_alu #(
    .AW (RW),
    .BW (BW),
    .DW (DW),
    .FB (F)
  ) u_alu (
    .clk  (clk),
    .rst  (rst),
    .ctl  (alu_ctl),
    .opa  (alu_a),
    .opb  (alu_b),
    .opd  (alu_d),
    .lim  (alu_lim),
    .done (alu_done),
    .res  (alu_res)
  );

  // sequencer, filter state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ax        <= '0;
      primed    <= 1'b0;
      err_var   <= LIM_ONE;
      pnv       <= CW'(LIM_ONE);
      mnv       <= CW'(LIM_ONE);
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        est[i]  <= '0;
        rate[i] <= '0;
      end
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          tmtf_pkg::CFG_PNV: pnv <= wr_data;
          tmtf_pkg::CFG_MNV: mnv <= wr_data;
          default: begin
          end
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            ax    <= '0;
            state <= ST_PRED_ISS;
          end
        end
        ST_PRED_ISS: state <= ST_PRED_WAIT;
        ST_PRED_WAIT: begin
          if (alu_done) begin
            if (ax == LAST_AX) begin
              ax <= '0;
              if (!upd_r) begin
                state <= ST_OUT;
              end else if (!was_r) begin
                // first update: load the observation and prime
                for (int i = 0; i < 3; i++) begin
                  est[i] <= obs_r[i];
                end
                primed <= 1'b1;
                state  <= ST_OUT;
              end else begin
                state <= ST_GAIN_ISS;
              end
            end else begin
              ax    <= ax + 2'd1;
              state <= ST_PRED_ISS;
            end
          end
        end
        ST_GAIN_ISS: state <= den_zero ? ST_CORR_ISS : ST_GAIN_WAIT;
        ST_GAIN_WAIT: begin
          if (alu_done) begin
            state <= ST_CORR_ISS;
          end
        end
        ST_CORR_ISS: state <= ST_CORR_WAIT;
        ST_CORR_WAIT: begin
          if (alu_done) begin
            est[ax] <= sat_w(est_sum);
            state   <= ST_RATE_ISS;
          end
        end
        ST_RATE_ISS: state <= ST_RATE_WAIT;
        ST_RATE_WAIT: begin
          if (alu_done) begin
            rate[ax] <= W'(sr);
            if (ax == LAST_AX) begin
              ax    <= '0;
              state <= ST_VAR_ISS;
            end else begin
              ax    <= ax + 2'd1;
              state <= ST_CORR_ISS;
            end
          end
        end
        ST_VAR_ISS: state <= ST_VAR_WAIT;
        ST_VAR_WAIT: begin
          if (alu_done) begin
            err_var <= alu_res;
            state   <= ST_OUT;
          end
        end
        ST_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // per-item data path registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      upd_r    <= (req_type == tmtf_pkg::REQ_UPDATE);
      was_r    <= primed;
      obs_r[0] <= obs_x;
      obs_r[1] <= obs_y;
      obs_r[2] <= obs_z;
      // a zero step counts as one LSB
      dt_r     <= (time_step == '0) ? DTW'(1) : time_step;
    end
    if (alu_ctl.start) begin
      neg_r <= issue_neg;
    end
    if (state == ST_PRED_WAIT && alu_done) begin
      pred[ax] <= was_r ? sat_w(pred_sum) : est[ax];
    end
    if (state == ST_GAIN_ISS && den_zero) begin
      gain <= LIM_ONE;
    end else if (state == ST_GAIN_WAIT && alu_done) begin
      gain <= alu_res;
    end
    if (out_load) begin
      // update words carry the new estimate, predict words the prediction
      out_x      <= upd_r ? est[0] : pred[0];
      out_y      <= upd_r ? est[1] : pred[1];
      out_z      <= upd_r ? est[2] : pred[2];
      was_primed <= was_r;
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    alu_done |-> (state == ST_PRED_WAIT || state == ST_GAIN_WAIT ||
                  state == ST_CORR_WAIT || state == ST_RATE_WAIT ||
                  state == ST_VAR_WAIT))
    else $error("shared unit finished outside a wait state");

  a_gain_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CORR_ISS) |-> (gain <= LIM_ONE))
    else $error("gain above one");

  a_primed_sticky: assert property (@(posedge clk) disable iff (rst)
    primed |=> primed)
    else $error("primed flag dropped without reset");

endmodule

`default_nettype wire

// ===== src/tmtf_alu.sv =====
// Shared iterative unit: shift-add multiply and restoring divide, saturated result.
`default_nettype none

module tmtf_alu #(
  parameter int AW = 32,
  parameter int BW = 24,
  parameter int DW = 33,
  parameter int FB = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tmtf_pkg::alu_ctl_t  ctl,
  input  wire logic [AW-1:0]       opa,
  input  wire logic [BW-1:0]       opb,
  input  wire logic [DW-1:0]       opd,
  input  wire logic [AW-1:0]       lim,
  output logic                     done,
  output logic [AW-1:0]            res
);

  localparam int PW    = AW + BW;
  localparam int NW    = AW + FB;
  localparam int SW    = (PW > DW + 2) ? PW : DW + 2;
  localparam int STEPS = (BW > NW) ? BW : NW;
  localparam int CW    = $clog2(STEPS + 1);

  logic          busy;
  logic          op;
  logic [CW-1:0] cnt;
  logic [PW-1:0] acc;
  logic [DW-1:0] rem;
  logic [AW-1:0] areg;
  logic [BW-1:0] breg;
  logic [DW-1:0] dreg;
  logic [AW-1:0] limr;

  logic [DW:0]   div_x;
  logic [SW-1:0] add_x;
  logic [SW-1:0] add_y;
  logic [SW-1:0] add_sum;
  logic          cin;
  logic          ge;
  logic [PW-1:0] val;
  logic          over;

  // one adder serves both: acc*2 + a for multiply, rem*2+bit - den for divide
  always_comb begin
    div_x = {rem, acc[NW-1]};
    if (op == tmtf_pkg::ALU_DIV) begin
      add_x = SW'(div_x);
      add_y = ~SW'(dreg);
      cin   = 1'b1;
    end else begin
      add_x = SW'({acc[PW-2:0], 1'b0});
      add_y = breg[BW-1] ? SW'(areg) : '0;
      cin   = 1'b0;
    end
    add_sum = add_x + add_y + SW'(cin);
    ge      = ~add_sum[SW-1];
    val     = (op == tmtf_pkg::ALU_DIV) ? PW'(acc[NW-1:0]) : PW'(acc[PW-1:FB]);
    over    = val > PW'(limr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op   <= tmtf_pkg::ALU_MUL;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        op   <= ctl.op;
        cnt  <= (ctl.op == tmtf_pkg::ALU_DIV) ? CW'(NW) : CW'(BW);
      end else if (busy) begin
        if (cnt != '0) begin
          cnt <= cnt - CW'(1);
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc  <= (ctl.op == tmtf_pkg::ALU_DIV) ? PW'({opa, {FB{1'b0}}}) : '0;
      rem  <= '0;
      areg <= opa;
      breg <= opb;
      dreg <= opd;
      limr <= lim;
    end else if (busy && cnt != '0) begin
      if (op == tmtf_pkg::ALU_DIV) begin
        acc <= {acc[PW-2:0], ge};
        rem <= ge ? add_sum[DW-1:0] : div_x[DW-1:0];
      end else begin
        acc  <= add_sum[PW-1:0];
        breg <= {breg[BW-2:0], 1'b0};
      end
    end else if (busy) begin
      res <= over ? limr : val[AW-1:0];
    end
  end

endmodule

`default_nettype wire
